@@ sv/niblack_local_threshold_assert.svh @@
// Assertion macros shared by the checker files of the thresholding block.
// Both expect signals named clock and reset in the scope where they are used.
`ifndef NIBLACK_LOCAL_THRESHOLD_ASSERT_SVH
`define NIBLACK_LOCAL_THRESHOLD_ASSERT_SVH

// Check a property outside of reset
`define NLT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every edge, reset included
`define NLT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/nlt_pkg.sv @@
// ----------------------------------------------------------------------------
// nlt_pkg
// Shared types and constants of the Niblack local threshold block.
// ----------------------------------------------------------------------------
`default_nettype none

package nlt_pkg;

   // Field widths
   localparam int PIXEL_W        = 8;
   localparam int FRAME_WIDTH_W  = 11;
   localparam int FRAME_HEIGHT_W = 13;
   localparam int HALF_W         = 4;
   localparam int K_W            = 14;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 14;

   // Frame geometry limits
   localparam int MAX_HEIGHT = 4096;
   localparam int ROW_W      = 12;
   localparam int MIN_WIDTH  = 2;
   localparam int MIN_HEIGHT = 2;

   // k is a fraction over 2**K_FRAC
   localparam int K_FRAC = 12;
   localparam int KK_W   = 2 * K_W;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HALF_WINDOW  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_K_SCALED     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_INVERT       = 3'd4;

   // Output pixel codes
   localparam logic [PIXEL_W-1:0] PIX_WHITE = 8'hFF;
   localparam logic [PIXEL_W-1:0] PIX_BLACK = 8'h00;

   // Commands from the sequencer to the datapath
   typedef struct packed {
      logic load;     // transfer in, read stores
      logic upd;      // update column and window sums
      logic rd_cen;   // read the center pixel
      logic mul1;     // products of area and sums
      logic mul2;     // differences
      logic mul3;     // squares and low partial product
      logic mul4;     // high partial product
      logic mul5;     // combine partial products
      logic emit;     // load the result register
   } nlt_cmd_type;

   // Status from the datapath to the sequencer
   typedef struct packed {
      logic interior;  // current pixel yields a result
      logic out_free;  // result register can take a value
   } nlt_status_type;

endpackage

`default_nettype wire

@@ sv/niblack_local_threshold.sv @@
// ----------------------------------------------------------------------------
// niblack_local_threshold
// Niblack adaptive binarization of a padded 8-bit raster stream.
// ----------------------------------------------------------------------------
// Each input transfer is one padded-image pixel in raster order; tuser marks
// the first pixel of a frame. One 0/255 result leaves for each interior pixel,
// with tlast on the frame's last one. A pixel without a result passes the load
// and update states; an interior one then the center read, the multiply steps
// and an output state that waits for the result register, an order set by the
// sequenced multiply chain of the threshold test and the single row-store port
// that serves both the old-row and center reads. A new pixel is taken while a
// finished result waits at the output. Geometry registers take effect at the
// next frame start; the others at once. No clearing pass runs after reset.
`default_nettype none

module niblack_local_threshold #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HALF  = 15
) (
   input  wire                               clock,
   input  wire                               reset,
   // input pixels
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [7:0]                        req_tdata,  // [7:0] pixel
   input  wire  [0:0]                        req_tuser,  // [0] frame_start
   // results
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [7:0]                        rsp_tdata,  // [7:0] binary_pixel
   output logic                              rsp_tlast,  // frame_last
   // register writes
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [nlt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [nlt_pkg::CSR_DATA_W-1:0]    csr_data
);

   nlt_pkg::nlt_cmd_type    cmd;
   nlt_pkg::nlt_status_type status;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   nlt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   nlt_datapath #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HALF  (MAX_HALF)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_pixel       (req_tdata),
      .req_frame_start (req_tuser[0]),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_pixel       (rsp_tdata),
      .rsp_last        (rsp_tlast),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

`default_nettype wire

@@ sv/nlt_ctrl.sv @@
// ----------------------------------------------------------------------------
// nlt_ctrl
// Sequencer stepping one pixel through the sum update and threshold test.
// ----------------------------------------------------------------------------
`default_nettype none

module nlt_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  nlt_pkg::nlt_status_type status,
   output nlt_pkg::nlt_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_UPD  = 4'd1;
   localparam logic [3:0] ST_CEN  = 4'd2;
   localparam logic [3:0] ST_M1   = 4'd3;
   localparam logic [3:0] ST_M2   = 4'd4;
   localparam logic [3:0] ST_M3   = 4'd5;
   localparam logic [3:0] ST_M4   = 4'd6;
   localparam logic [3:0] ST_M5   = 4'd7;
   localparam logic [3:0] ST_OUT  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.upd  = 1'b1;
            state_in = status.interior ? ST_CEN : ST_IDLE;
         end
         ST_CEN: begin
            cmd.rd_cen = 1'b1;
            state_in   = ST_M1;
         end
         ST_M1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_M2;
         end
         ST_M2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_M3;
         end
         ST_M3: begin
            cmd.mul3 = 1'b1;
            state_in = ST_M4;
         end
         ST_M4: begin
            cmd.mul4 = 1'b1;
            state_in = ST_M5;
         end
         ST_M5: begin
            cmd.mul5 = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/nlt_datapath.sv @@
// ----------------------------------------------------------------------------
// nlt_datapath
// Registers, row and column stores, running sums and the threshold test.
// ----------------------------------------------------------------------------
`default_nettype none

module nlt_datapath #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HALF  = 15
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_valid,
   input  wire  [nlt_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire  [nlt_pkg::CSR_DATA_W-1:0]        csr_data,
   input  wire  [nlt_pkg::PIXEL_W-1:0]           req_pixel,
   input  wire                                   req_frame_start,
   input  wire                                   rsp_tready,
   output logic                                  rsp_tvalid,
   output logic [nlt_pkg::PIXEL_W-1:0]           rsp_pixel,
   output logic                                  rsp_last,
   input  nlt_pkg::nlt_cmd_type                  cmd,
   output nlt_pkg::nlt_status_type               status
);

   localparam int PW    = nlt_pkg::PIXEL_W;
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WVW   = CW + 1;
   localparam int RW    = nlt_pkg::ROW_W;
   localparam int HGW   = nlt_pkg::FRAME_HEIGHT_W;
   localparam int HW    = $clog2(MAX_HALF + 1);
   localparam int SW    = HW + 1;
   localparam int AW    = 2 * SW;
   localparam int CSW   = PW + SW;
   localparam int CQW   = 2 * PW + SW;
   localparam int WSW   = PW + AW;
   localparam int WQW   = 2 * PW + AW;
   localparam int DW    = 2 * WSW;
   localparam int DLO   = (DW + 1) / 2;
   localparam int DHI   = DW - DLO;
   localparam int KKW   = nlt_pkg::KK_W;
   localparam int CMPW  = KKW + DW;
   localparam int DEPTH = 2 * MAX_HALF * MAX_WIDTH;
   localparam int RAW   = $clog2(DEPTH);
   localparam int XW    = ((CW > RW) ? CW : RW) + 3;

   // Configuration registers
   logic [nlt_pkg::FRAME_WIDTH_W-1:0]  width_ff;
   logic [nlt_pkg::FRAME_HEIGHT_W-1:0] height_ff;
   logic [nlt_pkg::HALF_W-1:0]         half_ff;
   logic signed [nlt_pkg::K_W-1:0]     k_ff;
   logic                               invert_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd640;
         height_ff <= 13'd480;
         half_ff   <= 4'd7;
         k_ff      <= -14'sd819;
         invert_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            nlt_pkg::REG_FRAME_WIDTH:  width_ff  <= csr_data[nlt_pkg::FRAME_WIDTH_W-1:0];
            nlt_pkg::REG_FRAME_HEIGHT: height_ff <= csr_data[nlt_pkg::FRAME_HEIGHT_W-1:0];
            nlt_pkg::REG_HALF_WINDOW:  half_ff   <= csr_data[nlt_pkg::HALF_W-1:0];
            nlt_pkg::REG_K_SCALED:     k_ff      <= $signed(csr_data[nlt_pkg::K_W-1:0]);
            nlt_pkg::REG_INVERT:       invert_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Saturate geometry registers to the supported range
   logic [WVW-1:0] w_cl;
   logic [HGW-1:0] h_cl;
   logic [HW-1:0]  half_cl;

   always_comb begin
      if (width_ff < 11'(nlt_pkg::MIN_WIDTH))        w_cl = WVW'(nlt_pkg::MIN_WIDTH);
      else if (32'(width_ff) > MAX_WIDTH)            w_cl = WVW'(MAX_WIDTH);
      else                                           w_cl = WVW'(width_ff);
      if (height_ff < 13'(nlt_pkg::MIN_HEIGHT))      h_cl = HGW'(nlt_pkg::MIN_HEIGHT);
      else if (32'(height_ff) > nlt_pkg::MAX_HEIGHT) h_cl = HGW'(nlt_pkg::MAX_HEIGHT);
      else                                           h_cl = height_ff;
      if (half_ff == 4'd0)                           half_cl = HW'(1);
      else if (32'(half_ff) > MAX_HALF)              half_cl = HW'(MAX_HALF);
      else                                           half_cl = HW'(half_ff);
   end

   // Frame counters and latched geometry
   logic [CW-1:0]  col_ff;
   logic [RW-1:0]  row_ff;
   logic [SW-1:0]  rph_ff;
   logic [WVW-1:0] act_w_ff;
   logic [HGW-1:0] act_h_ff;
   logic [HW-1:0]  act_half_ff;
   logic [AW-1:0]  area_ff;

   logic           frame0;
   logic [CW-1:0]  c0, c_cur;
   logic [RW-1:0]  r0;
   logic [SW-1:0]  rp0;
   logic [WVW-1:0] g_w;
   logic [HGW-1:0] g_h;
   logic [HW-1:0]  g_half;
   logic [SW-1:0]  g_side;
   logic [SW:0]    yt;
   logic [SW-1:0]  yph;
   logic [CW-1:0]  x_cen;
   logic [XW-1:0]  r_x, c_x, side_x, h_x, w_x;
   logic           interior_in, last_in;
   logic [CW-1:0]  col_in;
   logic [RW-1:0]  row_in;
   logic [SW-1:0]  rph_in;
   logic [RAW-1:0] slot_in, cen_in;

   always_comb begin
      frame0 = req_frame_start || (col_ff == '0 && row_ff == '0);
      c0     = req_frame_start ? '0 : col_ff;
      r0     = req_frame_start ? '0 : row_ff;
      rp0    = req_frame_start ? '0 : rph_ff;
      g_w    = frame0 ? w_cl    : act_w_ff;
      g_h    = frame0 ? h_cl    : act_h_ff;
      g_half = frame0 ? half_cl : act_half_ff;
      g_side = {g_half, 1'b0};
      c_cur  = ({1'b0, c0} >= g_w) ? '0 : c0;

      r_x    = XW'(r0);
      c_x    = XW'(c_cur);
      side_x = XW'(g_side);
      h_x    = XW'(g_h);
      w_x    = XW'(g_w);
      interior_in = (r_x + 1'b1 >= side_x) && (r_x + XW'(2) <= h_x) &&
                    (c_x + 1'b1 >= side_x) && (c_x + XW'(2) <= w_x);
      last_in     = (r_x + XW'(2) == h_x) && (c_x + XW'(2) == w_x);

      // Center row phase: (row + 1 - h) modulo side
      yt = {1'b0, rp0} + 1'b1;
      if (yt >= (SW+1)'(g_half)) yph = SW'(yt - (SW+1)'(g_half));
      else                       yph = SW'(yt + (SW+1)'(g_side) - (SW+1)'(g_half));
      x_cen = c_cur + 1'b1 - CW'(g_half);

      slot_in = RAW'(rp0) * RAW'(MAX_WIDTH) + RAW'(c_cur);
      cen_in  = RAW'(yph) * RAW'(MAX_WIDTH) + RAW'(x_cen);

      // Advance position
      col_in = c_cur + 1'b1;
      row_in = r0;
      rph_in = rp0;
      if ({1'b0, col_in} >= g_w || col_in == '0) begin
         col_in = '0;
         if (XW'(r0) + 1'b1 >= h_x) begin
            row_in = '0;
            rph_in = '0;
         end else begin
            row_in = r0 + 1'b1;
            rph_in = ({1'b0, rp0} + 1'b1 >= (SW+1)'(g_side)) ? '0 : rp0 + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         rph_ff      <= '0;
         act_w_ff    <= '0;
         act_h_ff    <= '0;
         act_half_ff <= HW'(1);
         area_ff     <= '0;
      end else if (cmd.load) begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         rph_ff      <= rph_in;
         act_w_ff    <= g_w;
         act_h_ff    <= g_h;
         act_half_ff <= g_half;
         area_ff     <= AW'(g_side) * AW'(g_side);
      end
   end

   // Per-pixel registers captured at the input transfer
   logic [PW-1:0]   pix_ff;
   logic [2*PW-1:0] pix_sq_ff;
   logic [CW-1:0]   c_ff;
   logic            rzero_ff, rge_ff, czero_ff, cge_ff;
   logic [RAW-1:0]  slot_ff, cen_ff;
   logic            interior_ff, last_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pix_ff      <= req_pixel;
         pix_sq_ff   <= req_pixel * req_pixel;
         c_ff        <= c_cur;
         rzero_ff    <= (r0 == '0);
         rge_ff      <= (r_x >= side_x);
         czero_ff    <= (c_cur == '0);
         cge_ff      <= (c_x >= side_x);
         slot_ff     <= slot_in;
         cen_ff      <= cen_in;
         interior_ff <= interior_in;
         last_ff     <= last_in;
      end
   end

   // Row store: last 2h rows of pixels
   logic [PW-1:0]  row_mem [DEPTH];
   logic [PW-1:0]  row_rd_ff;
   logic [RAW-1:0] row_rd_addr;

   assign row_rd_addr = cmd.load ? slot_in : cen_ff;

   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         row_mem[slot_ff] <= pix_ff;
      end
      if (cmd.load || cmd.rd_cen) begin
         row_rd_ff <= row_mem[row_rd_addr];
      end
   end

   // Column store: {square sum, sum}, read at the column and at column - side
   logic [CQW+CSW-1:0] col_mem [MAX_WIDTH];
   logic [CQW+CSW-1:0] col_cur_ff, col_old_ff;
   logic [CW-1:0]      col_old_addr;
   logic [CSW-1:0]     nsum;
   logic [CQW-1:0]     nsq;
   logic [2*PW-1:0]    old_sq;

   assign col_old_addr = c_cur - CW'(g_side);

   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         col_mem[c_ff] <= {nsq, nsum};
      end
      if (cmd.load) begin
         col_cur_ff <= col_mem[c_cur];
         col_old_ff <= col_mem[col_old_addr];
      end
   end

   // Column and window sum update
   logic [WSW-1:0] ws_ff;
   logic [WQW-1:0] wq_ff;

   always_comb begin
      old_sq = row_rd_ff * row_rd_ff;
      if (rzero_ff) begin
         nsum = CSW'(pix_ff);
         nsq  = CQW'(pix_sq_ff);
      end else begin
         nsum = col_cur_ff[CSW-1:0] + CSW'(pix_ff) - (rge_ff ? CSW'(row_rd_ff) : '0);
         nsq  = col_cur_ff[CQW+CSW-1:CSW] + CQW'(pix_sq_ff) - (rge_ff ? CQW'(old_sq) : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff <= '0;
         wq_ff <= '0;
      end else if (cmd.upd) begin
         if (czero_ff) begin
            ws_ff <= WSW'(nsum);
            wq_ff <= WQW'(nsq);
         end else begin
            ws_ff <= ws_ff + WSW'(nsum) - (cge_ff ? WSW'(col_old_ff[CSW-1:0]) : '0);
            wq_ff <= wq_ff + WQW'(nsq) -
                     (cge_ff ? WQW'(col_old_ff[CQW+CSW-1:CSW]) : '0);
         end
      end
   end

   // Threshold test without a root
   logic [WSW-1:0]  pa_ff, m_ff;
   logic [DW-1:0]   aq_ff, ss_ff, d_ff;
   logic [KKW-1:0]  kk_ff;
   logic            kneg_ff, lneg_ff;
   logic [DW-1:0]   l2_ff;
   logic [KKW+DLO-1:0] pl_ff;
   logic [KKW+DHI-1:0] ph_ff;
   logic [CMPW-1:0] rr_ff;
   logic [nlt_pkg::K_W-1:0] kmag;
   logic [CMPW-1:0] lsq;
   logic            dark;

   assign kmag = k_ff[nlt_pkg::K_W-1] ? nlt_pkg::K_W'(-k_ff) : nlt_pkg::K_W'(k_ff);
   assign lsq  = CMPW'(l2_ff) << (2 * nlt_pkg::K_FRAC);

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         pa_ff   <= WSW'(row_rd_ff) * WSW'(area_ff);
         aq_ff   <= DW'(area_ff) * DW'(wq_ff);
         ss_ff   <= DW'(ws_ff) * DW'(ws_ff);
         kk_ff   <= KKW'(kmag) * KKW'(kmag);
         kneg_ff <= k_ff[nlt_pkg::K_W-1];
      end
      if (cmd.mul2) begin
         lneg_ff <= (pa_ff < ws_ff);
         m_ff    <= (pa_ff < ws_ff) ? ws_ff - pa_ff : pa_ff - ws_ff;
         d_ff    <= (aq_ff > ss_ff) ? aq_ff - ss_ff : '0;
      end
      if (cmd.mul3) begin
         l2_ff <= DW'(m_ff) * DW'(m_ff);
         pl_ff <= (KKW+DLO)'(kk_ff) * (KKW+DLO)'(d_ff[DLO-1:0]);
      end
      if (cmd.mul4) begin
         ph_ff <= (KKW+DHI)'(kk_ff) * (KKW+DHI)'(d_ff[DW-1:DLO]);
      end
      if (cmd.mul5) begin
         rr_ff <= CMPW'(pl_ff) + (CMPW'(ph_ff) << DLO);
      end
   end

   assign dark = kneg_ff ? (lneg_ff && (rr_ff < lsq)) : (lneg_ff || (lsq < rr_ff));

   // Result register
   logic              rsp_valid_ff;
   logic [PW-1:0]     rsp_pixel_ff;
   logic              rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_pixel_ff <= (dark == invert_ff) ? nlt_pkg::PIX_WHITE : nlt_pkg::PIX_BLACK;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_pixel       = rsp_pixel_ff;
   assign rsp_last        = rsp_last_ff;
   assign status.interior = interior_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

endmodule

`default_nettype wire

@@ sv/nlt_checker.sv @@
// ----------------------------------------------------------------------------
// nlt_checker
// Port-level checks of the Niblack threshold block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "niblack_local_threshold_assert.svh"

module nlt_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_tvalid,
   input wire       req_tready,
   input wire       rsp_tvalid,
   input wire       rsp_tready,
   input wire [7:0] rsp_tdata,
   input wire       rsp_tlast
);

   // No result is pending right after reset
   `NLT_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result valid after reset")

   // A stalled result holds
   `NLT_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result changed")

   // Results are black or white only
   `NLT_ASSERT(a_rsp_binary, rsp_tvalid |-> (rsp_tdata == 8'h00 || rsp_tdata == 8'hFF), "result not 0 or 255")

   // A pixel is worked on alone: no transfer in the cycle after one
   `NLT_ASSERT(a_one_at_a_time, req_tvalid && req_tready |=> !req_tready, "input taken back to back")

endmodule

bind niblack_local_threshold nlt_checker u_nlt_checker (.*);

`default_nettype wire

@@ test/tb_niblack_local_threshold.sv @@
// ----------------------------------------------------------------------------
// tb_niblack_local_threshold
// Self-checking testbench of the Niblack local threshold block.
// ----------------------------------------------------------------------------
// Pixel frames are sent over the input stream while a local prediction of the
// running column and window sums computes each expected binary pixel and its
// end-of-frame flag. Results are compared in order. Several register settings
// are run, with random gaps on both streams.
`default_nettype none

module tb_niblack_local_threshold;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAXW     = 1024;
   localparam int MAXH     = 15;
   localparam int CYC_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [nlt_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [nlt_pkg::CSR_DATA_W-1:0] csr_data = '0;

   niblack_local_threshold dut (.*);

   typedef struct {
      logic [7:0] pix;
      logic       fs;
   } pixel_item_type;

   typedef struct {
      logic [7:0] bin;
      logic       last;
   } bin_result_type;

   pixel_item_type pixel_q[$];
   bin_result_type expected_bin_q[$];
   int errors = 0;
   int pixels_sent = 0;
   int results_seen = 0;
   longint cycles = 0;

   // Predictor state
   logic [10:0] p_width;
   logic [12:0] p_height;
   logic [3:0]  p_half;
   logic [13:0] p_k;
   logic        p_invert;
   logic [7:0]  p_rows [0:2*MAXH*MAXW-1];
   int unsigned p_colsum [0:MAXW-1];
   int unsigned p_colsq [0:MAXW-1];
   longint unsigned p_wsum, p_wsq;
   int unsigned p_col, p_row, p_aw, p_ah, p_ahalf;

   function automatic int unsigned clamp_range(int unsigned v, int unsigned lo,
                                               int unsigned hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Exact test 4096*(P*A - S) < k*sqrt(A*Q - S*S) in wide integers
   function automatic bit dark_pixel(int unsigned p, longint unsigned s,
                                     longint unsigned q, longint unsigned area);
      logic signed [13:0] ks;
      logic [63:0] pa, lmag, kmag, d, aq, ss;
      logic [127:0] lsq, rsq;
      bit lneg;
      ks   = p_k;
      pa   = 64'(p) * area;
      lneg = pa < s;
      lmag = 64'd4096 * (lneg ? s - pa : pa - s);
      aq   = area * q;
      ss   = s * s;
      d    = aq > ss ? aq - ss : 64'd0;
      kmag = ks < 0 ? 64'(-int'(ks)) : 64'(int'(ks));
      lsq  = 128'(lmag) * 128'(lmag);
      rsq  = 128'(kmag * kmag) * 128'(d);
      if (ks >= 0) return lneg || (lsq < rsq);
      return lneg && (rsq < lsq);
   endfunction

   task automatic predict_reset();
      p_width = 11'd640; p_height = 13'd480; p_half = 4'd7;
      p_k = 14'(-819); p_invert = 1'b1;
      foreach (p_colsum[i]) begin
         p_colsum[i] = 0; p_colsq[i] = 0;
      end
      p_wsum = 0; p_wsq = 0; p_col = 0; p_row = 0;
      p_aw = 640; p_ah = 480; p_ahalf = 7;
   endtask

   task automatic predict_csr(logic [nlt_pkg::CSR_INDEX_W-1:0] idx,
                              logic [nlt_pkg::CSR_DATA_W-1:0] val);
      case (idx)
         nlt_pkg::REG_FRAME_WIDTH:  p_width  = val[10:0];
         nlt_pkg::REG_FRAME_HEIGHT: p_height = 13'(val);
         nlt_pkg::REG_HALF_WINDOW:  p_half   = val[3:0];
         nlt_pkg::REG_K_SCALED:     p_k      = val;
         nlt_pkg::REG_INVERT:       p_invert = val[0];
         default: ;
      endcase
   endtask

   // Advance the running sums for one pixel; queue a result for interior ones
   task automatic predict_pixel(pixel_item_type it);
      int unsigned side, r, c, slot, old, p, y, x, cen;
      bit dk;
      bin_result_type res;
      p = it.pix;
      if (it.fs) begin
         p_col = 0; p_row = 0;
      end
      if (p_col == 0 && p_row == 0) begin
         p_aw = clamp_range(p_width, 2, MAXW);
         p_ah = clamp_range(p_height, 2, 4096);
         p_ahalf = clamp_range(p_half, 1, MAXH);
      end
      side = 2 * p_ahalf;
      r = p_row; c = p_col;
      if (c >= p_aw) c = 0;
      slot = (r % side) * MAXW + c;
      old = p_rows[slot];
      p_rows[slot] = it.pix;
      if (r == 0) begin
         p_colsum[c] = p; p_colsq[c] = p * p;
      end else begin
         p_colsum[c] += p; p_colsq[c] += p * p;
         if (r >= side) begin
            p_colsum[c] -= old; p_colsq[c] -= old * old;
         end
      end
      if (c == 0) begin
         p_wsum = p_colsum[0]; p_wsq = p_colsq[0];
      end else begin
         p_wsum += p_colsum[c]; p_wsq += p_colsq[c];
         if (c >= side) begin
            p_wsum -= p_colsum[c-side]; p_wsq -= p_colsq[c-side];
         end
      end
      if (r + 1 >= side && r + 2 <= p_ah && c + 1 >= side && c + 2 <= p_aw) begin
         y = r + 1 - p_ahalf; x = c + 1 - p_ahalf;
         cen = p_rows[(y % side) * MAXW + x];
         dk = dark_pixel(cen, p_wsum, p_wsq, longint'(side) * side);
         res.bin  = (dk == p_invert) ? nlt_pkg::PIX_WHITE : nlt_pkg::PIX_BLACK;
         res.last = (r + 2 == p_ah && c + 2 == p_aw);
         expected_bin_q.push_back(res);
      end
      c++;
      if (c >= p_aw) begin
         c = 0; r++;
         if (r >= p_ah) r = 0;
      end
      p_col = c; p_row = r;
   endtask

   task automatic report_mismatch(string what);
      errors++;
      $display("MISMATCH at cycle %0d: %s", cycles, what);
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Clock, reset, cycle limit
   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == 8) reset <= 1'b0;
      if (cycles > CYC_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   // Input driver: hold each pixel until its transfer, random gaps between
   int drv_gap = 0;
   bit quiet_phase = 1'b0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_pixel('{pix: req_tdata, fs: req_tuser[0]});
            pixels_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (drv_gap > 0) begin
               req_tvalid <= 1'b0;
               drv_gap <= drv_gap - 1;
            end else if (pixel_q.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= pixel_q[0].pix;
               req_tuser <= pixel_q[0].fs;
               void'(pixel_q.pop_front());
               drv_gap <= quiet_phase ? 0 : gap_len();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and random back-pressure
   always @(posedge clock) begin
      bin_result_type e;
      if (!reset) begin
         rsp_tready <= quiet_phase ? 1'b1 : (gap_len() == 0);
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_bin_q.size() == 0) begin
               report_mismatch("result with nothing expected");
            end else begin
               e = expected_bin_q.pop_front();
               if (rsp_tdata !== e.bin)
                  report_mismatch($sformatf("binary_pixel %0h, expected %0h",
                                            rsp_tdata, e.bin));
               if (rsp_tlast !== e.last)
                  report_mismatch($sformatf("frame_last %0b, expected %0b",
                                            rsp_tlast, e.last));
            end
         end
      end
   end

   task automatic write_csr(logic [nlt_pkg::CSR_INDEX_W-1:0] idx,
                            logic [nlt_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      predict_csr(idx, val);
   endtask

   // Wait until every queued pixel is taken and every result has come back
   task automatic drain();
      while (pixel_q.size() > 0)
         @(posedge clock);
      @(posedge clock);
      while (req_tvalid || expected_bin_q.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_geometry(int w, int h, int hw, int k, int inv);
      write_csr(nlt_pkg::REG_FRAME_WIDTH, nlt_pkg::CSR_DATA_W'(w));
      write_csr(nlt_pkg::REG_FRAME_HEIGHT, nlt_pkg::CSR_DATA_W'(h));
      write_csr(nlt_pkg::REG_HALF_WINDOW, nlt_pkg::CSR_DATA_W'(hw));
      write_csr(nlt_pkg::REG_K_SCALED, nlt_pkg::CSR_DATA_W'(k));
      write_csr(nlt_pkg::REG_INVERT, nlt_pkg::CSR_DATA_W'(inv));
   endtask

   // One frame; style picks random, bimodal, gradient or flat content
   task automatic queue_frame(int w, int h, int style);
      pixel_item_type it;
      for (int i = 0; i < w * h; i++) begin
         case (style)
            0: it.pix = $urandom_range(0, 255);
            1: it.pix = 8'($urandom_range(0, 1) ? 255 : 0);
            2: it.pix = 8'((i * 7) + $urandom_range(0, 15));
            default: it.pix = 8'($urandom_range(100, 104));
         endcase
         it.fs = (i == 0);
         pixel_q.push_back(it);
      end
   endtask

   int sum_frames;
   initial begin
      int w, h, hw, k, n;
      pixel_item_type it;
      predict_reset();
      wait (!reset);
      @(posedge clock);

      // Directed: small window, extremes of pixel and k
      set_geometry(4, 4, 1, 8191, 0);
      queue_frame(4, 4, 1);
      drain();
      set_geometry(3, 3, 1, -8192, 1);
      it = '{pix: 8'hFF, fs: 1'b1}; pixel_q.push_back(it);
      for (int i = 1; i < 9; i++) pixel_q.push_back('{pix: 8'(i * 30), fs: 1'b0});
      drain();
      // Window larger than frame: no results
      set_geometry(2, 2, 3, 0, 0);
      queue_frame(2, 2, 0);
      drain();
      // Out of range width, height and half window saturate
      set_geometry(0, 0, 0, 0, 1);
      queue_frame(2, 2, 3);
      drain();
      // Frames run back to back without frame_start after the first
      set_geometry(4, 3, 1, 2048, 1);
      queue_frame(4, 3, 0);
      for (int i = 0; i < 12; i++) pixel_q.push_back('{pix: 8'($urandom), fs: 1'b0});
      drain();

      // Random frames in several settings
      sum_frames = 0;
      while (pixels_sent < 250) begin
         quiet_phase = ($urandom_range(0, 4) == 0);
         hw = $urandom_range(0, 9) == 0 ? $urandom_range(2, 3) : 1;
         w  = $urandom_range(2 * hw, 2 * hw + 10);
         h  = $urandom_range(2 * hw, 2 * hw + 6);
         k = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 8191 : -8192)
                                       : int'($urandom_range(0, 16383)) - 8192;
         set_geometry(w, h, hw, k, $urandom_range(0, 1));
         n = $urandom_range(1, 2);
         for (int f = 0; f < n; f++) queue_frame(w, h, $urandom_range(0, 3));
         // Occasional extra frame in the same setting
         if ($urandom_range(0, 5) == 0)
            queue_frame(w, h, 0);
         drain();
         sum_frames++;
      end

      // Width saturates to the longest row; restart early in the second row
      quiet_phase = 1'b0;
      set_geometry(2047, 2, 1, 1500, 0);
      for (int i = 0; i < 1027; i++) begin
         it.pix = 8'($urandom_range(0, 255));
         it.fs  = (i == 0);
         pixel_q.push_back(it);
      end
      drain();

      // A frame of the largest half window
      set_geometry(31, 31, 15, 1000, 1);
      queue_frame(31, 31, 0);
      drain();

      $display("Sent %0d pixels over %0d random settings, checked %0d results",
               pixels_sent, sum_frames, results_seen);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+sv
sv/nlt_pkg.sv
sv/nlt_ctrl.sv
sv/nlt_datapath.sv
sv/niblack_local_threshold.sv
sv/nlt_checker.sv
test/tb_niblack_local_threshold.sv
